>>> src/gos_pkg.sv
// Package for the graph ordering select unit.
// Holds the item structs, mode and ordering codes, and size constants.
// Used by gos_core and graph_ordering_select_unit; depends on nothing.
package gos_pkg;

	localparam int MaxV = 32;
	localparam int VW = $clog2(MaxV);
	localparam int CW = VW + 1;

	localparam logic [1:0] MODE_AUTO = 2'd0;
	localparam logic [1:0] MODE_IDENT = 2'd1;
	localparam logic [1:0] MODE_RCM = 2'd2;

	localparam logic [1:0] ORD_IDENT = 2'd0;
	localparam logic [1:0] ORD_CM = 2'd1;
	localparam logic [1:0] ORD_RCM = 2'd2;

	localparam logic CFG_VCOUNT = 1'b0;
	localparam logic CFG_MODE = 1'b1;

	typedef struct packed {
		logic [4:0] row_index;
		logic [31:0] row_bits;
		logic last_row;
	} in_item_t;

	typedef struct packed {
		logic [4:0] order_position;
		logic [4:0] order_vertex;
		logic [5:0] max_frontier;
		logic [4:0] bandwidth;
		logic [12:0] edge_span_sum;
		logic [1:0] chosen_ordering;
		logic last_result;
	} out_item_t;

	typedef struct packed {
		logic load;
		logic [CW-1:0] count;
		logic [1:0] mode;
	} core_ctl_t;

endpackage

>>> src/gos_core.sv
// Sequencer of the ordering unit: row store, neighbor build, degree sort,
// breadth-first searches, scoring and selection.
// Depends on gos_pkg.
module gos_core (
	input logic clk,
	input logic arst_n,
	input gos_pkg::core_ctl_t ctl,
	input gos_pkg::in_item_t item,
	output logic busy,
	output logic res_valid,
	input logic res_take,
	output gos_pkg::out_item_t res
);

	localparam int VW = gos_pkg::VW;
	localparam int CW = gos_pkg::CW;
	localparam int MaxV = gos_pkg::MaxV;

	typedef enum logic [3:0] {
		ST_IDLE, ST_BUILD, ST_SORT, ST_GEN, ST_ROOT, ST_HEAD, ST_REV,
		ST_POS, ST_SCORE, ST_CMP, ST_LEX, ST_EMIT
	} state_t;

	state_t state_q;

	logic [MaxV-1:0] adj_q [MaxV];
	logic [MaxV-1:0] nbr_q [MaxV];
	logic [CW-1:0] deg_q [MaxV];
	logic [VW-1:0] srt_q [MaxV];
	logic [VW-1:0] work_q [MaxV];
	logic [VW-1:0] best_q [MaxV];
	logic [VW-1:0] pos_q [MaxV];
	logic [CW-1:0] rel_q [MaxV];
	logic [MaxV-1:0] taken_q, vis_q;

	logic [CW-1:0] n_q, i_q, j_q, k_q, cnt_q, head_q, start_q, lo_q, hi_q;
	logic [1:0] mode_q, cand_q, chosen_q;
	logic [VW-1:0] sel_q, last_q;
	logic found_q, first_q;
	logic [CW-1:0] fr_q, frmax_q, bf_q;
	logic [VW-1:0] band_q, bb_q;
	logic [12:0] span_q, bs_q;

	logic [VW-1:0] vi, ji, su, hv, sv, pu, gap, win, last_n;
	logic [CW-1:0] nm1, cnt_nx, fr_n;
	logic [MaxV:0] live_w;
	logic [MaxV-1:0] col, nm;
	logic cand_ok, push, edge_b, auto_m, sc_lt, sc_eq, rev;

	always_comb begin
		vi = i_q[VW-1:0];
		ji = j_q[VW-1:0];
		nm1 = n_q - CW'(1);
		live_w = ((MaxV+1)'(1) << n_q) - (MaxV+1)'(1);
		for (int u = 0; u < MaxV; u++) begin
			col[u] = adj_q[u][vi];
		end
		nm = (adj_q[vi] | col) & live_w[MaxV-1:0] & ~(MaxV'(1) << vi);
		cand_ok = !taken_q[vi] && (!found_q || ({deg_q[vi], vi} < {deg_q[sel_q], sel_q}));
		win = cand_ok ? vi : sel_q;
		su = srt_q[vi];
		hv = work_q[head_q[VW-1:0]];
		push = nbr_q[hv][su] && !vis_q[su];
		cnt_nx = cnt_q + CW'(push);
		sv = work_q[vi];
		pu = pos_q[ji];
		edge_b = nbr_q[sv][ji];
		gap = (pu > vi) ? pu - vi : vi - pu;
		last_n = (edge_b && pu > last_q) ? pu : last_q;
		fr_n = fr_q - rel_q[vi] + CW'(last_n > vi);
		auto_m = (mode_q != gos_pkg::MODE_IDENT) && (mode_q != gos_pkg::MODE_RCM);
		sc_lt = {frmax_q, band_q, span_q} < {bf_q, bb_q, bs_q};
		sc_eq = {frmax_q, band_q, span_q} == {bf_q, bb_q, bs_q};
		rev = (cand_q == gos_pkg::ORD_RCM);
	end

	assign busy = (state_q != ST_IDLE);
	assign res_valid = (state_q == ST_EMIT);

	always_comb begin
		res.order_position = vi;
		res.order_vertex = best_q[vi];
		res.max_frontier = bf_q;
		res.bandwidth = bb_q;
		res.edge_span_sum = bs_q;
		res.chosen_ordering = chosen_q;
		res.last_result = (i_q == nm1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			vis_q <= '0;
			taken_q <= '0;
			found_q <= 1'b0;
			first_q <= 1'b0;
			i_q <= '0;
			bf_q <= '0;
			bb_q <= '0;
			bs_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (ctl.load) begin
						adj_q[item.row_index] <= item.row_bits;
						if (item.last_row) begin
							n_q <= ctl.count;
							mode_q <= ctl.mode;
							i_q <= '0;
							state_q <= ST_BUILD;
						end
					end
				end
				ST_BUILD: begin
					nbr_q[vi] <= nm;
					deg_q[vi] <= CW'($countones(nm));
					if (i_q == nm1) begin
						i_q <= '0;
						k_q <= '0;
						taken_q <= '0;
						found_q <= 1'b0;
						state_q <= ST_SORT;
					end else begin
						i_q <= i_q + CW'(1);
					end
				end
				ST_SORT: begin
					if (i_q == nm1) begin
						srt_q[k_q[VW-1:0]] <= win;
						taken_q[win] <= 1'b1;
						found_q <= 1'b0;
						i_q <= '0;
						k_q <= k_q + CW'(1);
						if (k_q == nm1) begin
							first_q <= 1'b1;
							cand_q <= (mode_q == gos_pkg::MODE_RCM) ? gos_pkg::ORD_RCM
								: gos_pkg::ORD_IDENT;
							state_q <= ST_GEN;
						end
					end else begin
						if (cand_ok) begin
							sel_q <= vi;
							found_q <= 1'b1;
						end
						i_q <= i_q + CW'(1);
					end
				end
				ST_GEN: begin
					i_q <= '0;
					if (cand_q == gos_pkg::ORD_IDENT) begin
						for (int x = 0; x < MaxV; x++) begin
							work_q[x] <= VW'(x);
						end
						state_q <= ST_POS;
					end else begin
						vis_q <= '0;
						cnt_q <= '0;
						state_q <= ST_ROOT;
					end
				end
				ST_ROOT: begin
					if (!vis_q[su]) begin
						work_q[cnt_q[VW-1:0]] <= su;
						vis_q[su] <= 1'b1;
						start_q <= cnt_q;
						head_q <= cnt_q;
						cnt_q <= cnt_q + CW'(1);
						i_q <= '0;
						state_q <= ST_HEAD;
					end else begin
						i_q <= i_q + CW'(1);
					end
				end
				ST_HEAD: begin
					if (push) begin
						work_q[cnt_q[VW-1:0]] <= su;
						vis_q[su] <= 1'b1;
					end
					cnt_q <= cnt_nx;
					if (i_q == nm1) begin
						i_q <= '0;
						head_q <= head_q + CW'(1);
						if (head_q + CW'(1) >= cnt_nx) begin
							if (rev) begin
								lo_q <= start_q;
								hi_q <= cnt_nx - CW'(1);
								state_q <= ST_REV;
							end else if (cnt_nx == n_q) begin
								state_q <= ST_POS;
							end else begin
								state_q <= ST_ROOT;
							end
						end
					end else begin
						i_q <= i_q + CW'(1);
					end
				end
				ST_REV: begin
					i_q <= '0;
					if (lo_q < hi_q) begin
						work_q[lo_q[VW-1:0]] <= work_q[hi_q[VW-1:0]];
						work_q[hi_q[VW-1:0]] <= work_q[lo_q[VW-1:0]];
						lo_q <= lo_q + CW'(1);
						hi_q <= hi_q - CW'(1);
					end else if (cnt_q == n_q) begin
						state_q <= ST_POS;
					end else begin
						state_q <= ST_ROOT;
					end
				end
				ST_POS: begin
					pos_q[sv] <= vi;
					rel_q[vi] <= '0;
					if (i_q == nm1) begin
						i_q <= '0;
						j_q <= '0;
						fr_q <= '0;
						frmax_q <= '0;
						band_q <= '0;
						span_q <= '0;
						last_q <= '0;
						state_q <= ST_SCORE;
					end else begin
						i_q <= i_q + CW'(1);
					end
				end
				ST_SCORE: begin
					if (edge_b) begin
						if (gap > band_q) begin
							band_q <= gap;
						end
						if (sv < ji) begin
							span_q <= span_q + 13'(gap);
						end
					end
					if (j_q == nm1) begin
						j_q <= '0;
						if (last_n > vi) begin
							rel_q[last_n] <= rel_q[last_n] + CW'(1);
						end
						fr_q <= fr_n;
						if (fr_n > frmax_q) begin
							frmax_q <= fr_n;
						end
						last_q <= VW'(i_q + CW'(1));
						i_q <= i_q + CW'(1);
						if (i_q == nm1) begin
							state_q <= ST_CMP;
						end
					end else begin
						last_q <= last_n;
						j_q <= j_q + CW'(1);
					end
				end
				ST_CMP, ST_LEX: begin
					logic keep, skip;
					keep = 1'b0;
					skip = 1'b0;
					if (state_q == ST_CMP) begin
						if (first_q || sc_lt) begin
							keep = 1'b1;
						end else if (!sc_eq) begin
							skip = 1'b1;
						end
					end else if (work_q[vi] != best_q[vi]) begin
						keep = (work_q[vi] < best_q[vi]);
						skip = !keep;
					end else if (i_q == nm1) begin
						skip = 1'b1;
					end
					if (keep) begin
						for (int x = 0; x < MaxV; x++) begin
							best_q[x] <= work_q[x];
						end
						bf_q <= frmax_q;
						bb_q <= band_q;
						bs_q <= span_q;
						chosen_q <= cand_q;
					end
					first_q <= 1'b0;
					i_q <= (state_q == ST_CMP || keep || skip) ? '0 : i_q + CW'(1);
					if (keep || skip) begin
						if (auto_m && cand_q != gos_pkg::ORD_RCM) begin
							cand_q <= cand_q + 2'd1;
							state_q <= ST_GEN;
						end else begin
							state_q <= ST_EMIT;
						end
					end else begin
						state_q <= ST_LEX;
					end
				end
				ST_EMIT: begin
					if (res_take) begin
						i_q <= i_q + CW'(1);
						if (i_q == nm1) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

>>> src/graph_ordering_select_unit.sv
// Top level of the graph ordering select unit.
// Holds the configuration registers and the result output register.
// Depends on gos_pkg and gos_core.
//
// Rows enter on the in channel (in_valid, in_stall, in_item), one per
// cycle while in_stall is low. A row with last_row set starts the ordering
// work; in_stall is high until the last result of that run has been handed
// to the output register. For n vertices the work is a build pass and a
// degree sort, then per candidate ordering a setup step, a search (none for
// identity), scoring and selection; auto mode tries three candidates.
// Results leave on the out channel, one item per position, n items in all,
// at most one per cycle; a stalled output item holds while the sequencer
// waits behind it.
// cfg_we writes vertex_count (index 0) or ordering_mode (index 1); write
// them only while the unit is idle.
// Reset clears the configuration to 32 vertices and auto mode and empties
// the output register; stored rows are undefined until written.
module graph_ordering_select_unit (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input gos_pkg::in_item_t in_item,
	output logic out_valid,
	input logic out_stall,
	output gos_pkg::out_item_t out_item,
	input logic cfg_we,
	input logic cfg_index,
	input logic [5:0] cfg_data
);

	logic [5:0] vcount_q;
	logic [1:0] mode_q;
	logic out_valid_q;
	gos_pkg::out_item_t out_item_q;
	gos_pkg::core_ctl_t ctl;
	gos_pkg::out_item_t res;
	logic busy, res_valid, res_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= 6'd32;
			mode_q <= gos_pkg::MODE_AUTO;
		end else if (cfg_we) begin
			case (cfg_index)
				gos_pkg::CFG_VCOUNT: vcount_q <= cfg_data;
				gos_pkg::CFG_MODE: mode_q <= cfg_data[1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		ctl.load = in_valid && !busy;
		ctl.mode = mode_q;
		if (vcount_q == 6'd0) begin
			ctl.count = gos_pkg::CW'(1);
		end else if (vcount_q > 6'(gos_pkg::MaxV)) begin
			ctl.count = gos_pkg::CW'(gos_pkg::MaxV);
		end else begin
			ctl.count = gos_pkg::CW'(vcount_q);
		end
	end

	assign in_stall = busy;
	assign res_take = res_valid && (!out_valid_q || !out_stall);

	gos_core u_core (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(ctl),
		.item(in_item),
		.busy(busy),
		.res_valid(res_valid),
		.res_take(res_take),
		.res(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || !out_stall) begin
			out_valid_q <= res_valid;
			if (res_valid) begin
				out_item_q <= res;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_item = out_item_q;

endmodule

>>> tb/graph_ordering_select_unit_chk.sv
// Checker for the graph ordering select unit: watches the row, result and
// configuration ports, predicts each run of ordering results and compares.
// Depends on gos_pkg; instantiated by graph_ordering_select_unit_tb.
module graph_ordering_select_unit_chk (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input gos_pkg::in_item_t in_item,
	input logic out_valid,
	input logic out_stall,
	input gos_pkg::out_item_t out_item,
	input logic cfg_we,
	input logic cfg_index,
	input logic [5:0] cfg_data,
	output int fail_count,
	output int pending_count
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [31:0] rows [32];
	logic [31:0] nbr [32];
	int deg [32];
	int work [32];
	int best [32];
	int best_f, best_b, best_s;
	logic [5:0] vcount;
	logic [1:0] mode;
	gos_pkg::out_item_t expected_results [$];

	function automatic bit key_less(int a, int b);
		return deg[a] < deg[b] || (deg[a] == deg[b] && a < b);
	endfunction

	function automatic void build_nbr(int n);
		for (int v = 0; v < n; v++) begin
			logic [31:0] m;
			m = rows[v];
			for (int u = 0; u < n; u++)
				if (rows[u][v]) m[u] = 1'b1;
			for (int u = n; u < 32; u++) m[u] = 1'b0;
			m[v] = 1'b0;
			nbr[v] = m;
			deg[v] = $countones(m);
		end
	endfunction

	function automatic void search_order(int n, bit rev);
		logic [31:0] seen;
		int count;
		seen = '0;
		count = 0;
		while (count < n) begin
			int root, start, t, lo, hi;
			bit found;
			found = 0;
			root = 0;
			for (int v = 0; v < n; v++)
				if (!seen[v] && (!found || key_less(v, root))) begin
					root = v;
					found = 1;
				end
			seen[root] = 1'b1;
			start = count;
			work[count++] = root;
			for (int h = start; h < count; h++) begin
				logic [31:0] cand;
				cand = nbr[work[h]] & ~seen;
				while (cand != 0) begin
					int pick;
					bit got;
					got = 0;
					pick = 0;
					for (int u = 0; u < n; u++)
						if (cand[u] && (!got || key_less(u, pick))) begin
							pick = u;
							got = 1;
						end
					cand[pick] = 1'b0;
					seen[pick] = 1'b1;
					work[count++] = pick;
				end
			end
			if (rev) begin
				lo = start;
				hi = count - 1;
				while (lo < hi) begin
					t = work[lo];
					work[lo] = work[hi];
					work[hi] = t;
					lo++;
					hi--;
				end
			end
		end
	endfunction

	function automatic void score(int n, output int f, output int b, output int s);
		int pos [32];
		int rel [32];
		int fr;
		f = 0; b = 0; s = 0; fr = 0;
		for (int i = 0; i < n; i++) begin
			pos[work[i]] = i;
			rel[i] = 0;
		end
		for (int i = 0; i < n; i++) begin
			int v, last, d;
			v = work[i];
			last = i;
			fr -= rel[i];
			for (int u = 0; u < n; u++)
				if (nbr[v][u]) begin
					d = pos[u] > i ? pos[u] - i : i - pos[u];
					if (d > b) b = d;
					if (v < u) s += d;
					if (pos[u] > last) last = pos[u];
				end
			if (last > i) begin
				fr++;
				rel[last]++;
			end
			if (fr > f) f = fr;
		end
	endfunction

	function automatic bit beats_kept(int f, int b, int s, int n);
		if (f != best_f) return f < best_f;
		if (b != best_b) return b < best_b;
		if (s != best_s) return s < best_s;
		for (int i = 0; i < n; i++)
			if (work[i] != best[i]) return work[i] < best[i];
		return 0;
	endfunction

	function automatic void keep_order(int f, int b, int s, int n);
		best_f = f; best_b = b; best_s = s;
		for (int i = 0; i < n; i++) best[i] = work[i];
	endfunction

	function automatic void predict_ordering();
		int n, f, b, s;
		logic [1:0] chosen;
		gos_pkg::out_item_t r;
		n = vcount == 0 ? 1 : (vcount > 32 ? 32 : int'(vcount));
		build_nbr(n);
		if (mode == gos_pkg::MODE_IDENT || mode == gos_pkg::MODE_AUTO || mode == 2'd3) begin
			for (int i = 0; i < n; i++) work[i] = i;
			score(n, f, b, s);
			keep_order(f, b, s, n);
			chosen = gos_pkg::ORD_IDENT;
		end
		if (mode == gos_pkg::MODE_RCM) begin
			search_order(n, 1);
			score(n, f, b, s);
			keep_order(f, b, s, n);
			chosen = gos_pkg::ORD_RCM;
		end else if (mode != gos_pkg::MODE_IDENT) begin
			search_order(n, 0);
			score(n, f, b, s);
			if (beats_kept(f, b, s, n)) begin
				keep_order(f, b, s, n);
				chosen = gos_pkg::ORD_CM;
			end
			search_order(n, 1);
			score(n, f, b, s);
			if (beats_kept(f, b, s, n)) begin
				keep_order(f, b, s, n);
				chosen = gos_pkg::ORD_RCM;
			end
		end
		for (int i = 0; i < n; i++) begin
			r.order_position = i[4:0];
			r.order_vertex = best[i][4:0];
			r.max_frontier = best_f[5:0];
			r.bandwidth = best_b[4:0];
			r.edge_span_sum = best_s[12:0];
			r.chosen_ordering = chosen;
			r.last_result = (i == n - 1);
			expected_results = {expected_results, r};
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount <= 6'd32;
			mode <= gos_pkg::MODE_AUTO;
			fail_count <= 0;
			pending_count <= 0;
			expected_results.delete();
		end else begin
			if (cfg_we) begin
				if (cfg_index == gos_pkg::CFG_VCOUNT) vcount <= cfg_data;
				else mode <= cfg_data[1:0];
			end
			if (in_valid && !in_stall) begin
				rows[in_item.row_index] = in_item.row_bits;
				if (in_item.last_row) predict_ordering();
			end
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					$error("unexpected result item %p", out_item);
					fail_count <= fail_count + 1;
				end else begin
					gos_pkg::out_item_t e;
					int bad;
					e = expected_results.pop_front();
					bad = 0;
					if (e.order_position !== out_item.order_position) begin
						$error("order_position exp %0d got %0d", e.order_position,
							out_item.order_position);
						bad++;
					end
					if (e.order_vertex !== out_item.order_vertex) begin
						$error("order_vertex exp %0d got %0d", e.order_vertex,
							out_item.order_vertex);
						bad++;
					end
					if (e.max_frontier !== out_item.max_frontier) begin
						$error("max_frontier exp %0d got %0d", e.max_frontier,
							out_item.max_frontier);
						bad++;
					end
					if (e.bandwidth !== out_item.bandwidth) begin
						$error("bandwidth exp %0d got %0d", e.bandwidth, out_item.bandwidth);
						bad++;
					end
					if (e.edge_span_sum !== out_item.edge_span_sum) begin
						$error("edge_span_sum exp %0d got %0d", e.edge_span_sum,
							out_item.edge_span_sum);
						bad++;
					end
					if (e.chosen_ordering !== out_item.chosen_ordering) begin
						$error("chosen_ordering exp %0d got %0d", e.chosen_ordering,
							out_item.chosen_ordering);
						bad++;
					end
					if (e.last_result !== out_item.last_result) begin
						$error("last_result exp %0d got %0d", e.last_result,
							out_item.last_result);
						bad++;
					end
					fail_count <= fail_count + bad;
				end
			end
			pending_count <= expected_results.size();
		end
	end
endmodule

>>> tb/graph_ordering_select_unit_tb.sv
// Testbench top for the graph ordering select unit: loads graphs row by row
// under several vertex counts and modes, with random idling on both sides.
// Depends on gos_pkg, graph_ordering_select_unit and its checker module.
module graph_ordering_select_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WatchdogLimit = 200000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	gos_pkg::in_item_t in_item = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	gos_pkg::out_item_t out_item;
	logic cfg_we = 1'b0;
	logic cfg_index = gos_pkg::CFG_VCOUNT;
	logic [5:0] cfg_data = '0;
	int fail_count, pending_count;
	int idle_cycles = 0;
	bit quiet = 0;
	bit hold_long = 0;

	always #2 clk = ~clk;

	graph_ordering_select_unit DUT (.*);
	graph_ordering_select_unit_chk checker_i (.*);

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WatchdogLimit) begin
			$display("graph_ordering_select_unit_tb: FAIL");
			$finish;
		end
	end

	initial begin
		int burst;
		forever begin
			@(posedge clk);
			if (hold_long) begin
				wait (out_valid);
				@(posedge clk);
				out_stall <= 1'b1;
				repeat (3000) @(posedge clk);
				out_stall <= 1'b0;
				wait (!hold_long);
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				burst = $urandom_range(1, 10);
				out_stall <= 1'b1;
				repeat (burst) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	task automatic send_row(input logic [4:0] idx, input logic [31:0] bits, input bit last);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= '{row_index: idx, row_bits: bits, last_row: last};
		do @(posedge clk); while (in_stall);
	endtask

	task automatic write_regs(input logic [5:0] mode_value, input logic [5:0] count_value);
		cfg_we <= 1'b1;
		cfg_index <= gos_pkg::CFG_MODE;
		cfg_data <= mode_value;
		@(posedge clk);
		cfg_index <= gos_pkg::CFG_VCOUNT;
		cfg_data <= count_value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		wait (pending_count == 0);
		repeat (20000) @(posedge clk);
	endtask

	// Every row 0..31 is written so no unwritten row is ever read.
	task automatic send_graph(input int kind);
		logic [31:0] bits;
		for (int v = 0; v < 32; v++) begin
			case (kind)
				0: bits = 32'h0;
				1: bits = 32'hFFFF_FFFF;
				2: bits = (v > 0 ? 32'd1 << (v - 1) : 32'd0) | (32'd1 << (v + 1));
				default: begin
					bits = 0;
					for (int u = 0; u < 32; u++)
						if ($urandom_range(0, 99) < kind) bits[u] = 1'b1;
					if ($urandom_range(0, 3) == 0) bits = $urandom;
				end
			endcase
			send_row(v[4:0], bits, v == 31);
		end
	endtask

	initial begin
		logic [1:0] modes [4] = '{gos_pkg::MODE_AUTO, gos_pkg::MODE_IDENT, gos_pkg::MODE_RCM,
			2'd3};
		int sizes [7] = '{1, 32, 2, 0, 63, 5, 17};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_graph(2);
		drain_results();
		for (int m = 0; m < 4; m++) begin
			write_regs({4'd0, modes[m]}, 6'(sizes[m + m % 2]));
			send_graph(m == 0 ? 0 : (m == 1 ? 1 : 30));
			drain_results();
		end
		hold_long = 1;
		send_graph(20);
		send_row(5'd3, 32'h0000_0010, 1'b1);
		drain_results();
		hold_long = 0;
		for (int k = 0; k < 8; k++) begin
			if (k == 6) quiet = 1;
			write_regs(6'($urandom_range(0, 3)), k % 3 == 0 ?
				6'(sizes[$urandom_range(0, 6)]) : 6'($urandom_range(1, 12)));
			send_graph($urandom_range(3, 60));
			drain_results();
		end
		if (fail_count == 0)
			$display("graph_ordering_select_unit_tb: PASS");
		else
			$display("graph_ordering_select_unit_tb: FAIL");
		$finish;
	end
endmodule

>>> sim.f
src/gos_pkg.sv
src/gos_core.sv
src/graph_ordering_select_unit.sv
tb/graph_ordering_select_unit_chk.sv
tb/graph_ordering_select_unit_tb.sv
